### design/mpb_pkg.sv
// Shared constants, codes and types of the motor pulse brake sequencer.
`timescale 1ns / 1ps
`default_nettype none
package mpb_pkg;

	localparam int DUTY_BITS_DEF = 10;
	localparam int TIME_BITS_DEF = 16;

	localparam int SPEED_W   = 11;
	localparam int ON_W      = 16;
	localparam int MAXD_W    = 10;
	localparam int CAP_W     = 10;
	localparam int GAIN_W    = 9;
	localparam int LIM_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CMP_W     = 17;
	localparam int GAIN_FRAC = 8;
	localparam int PROD_W    = SPEED_W + GAIN_W + 1;
	localparam int BRAKE_DIV = 5;

	localparam logic [MAXD_W-1:0] MAX_DUTY_RST   = 10'd1023;
	localparam logic [CAP_W-1:0]  DRIVE_CAP_RST  = 10'd1023;
	localparam logic [GAIN_W-1:0] BRAKE_GAIN_RST = 9'd128;
	localparam logic [LIM_W-1:0]  BRAKE_LIM_RST  = 16'd20;
	localparam logic [PROD_W-1:0] ROUND_HALF     = PROD_W'(1 << (GAIN_FRAC - 1));

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_DUTY   = 2'd0,
		CFG_DRIVE_CAP  = 2'd1,
		CFG_BRAKE_GAIN = 2'd2,
		CFG_BRAKE_LIM  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PHC_IDLE  = 2'd0,
		PHC_DRIVE = 2'd1,
		PHC_BRAKE = 2'd2,
		PHC_LOCK  = 2'd3
	} phase_code_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_REFUSED = 2'd1,
		ST_BUSY    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		DIR_COAST = 2'd0,
		DIR_FWD   = 2'd1,
		DIR_REV   = 2'd2
	} dir_t;

	typedef struct packed {
		phase_code_t phase;
		status_t     status;
		logic        zero;
	} res_info_t;

endpackage
`default_nettype wire

### design/mpb_if.sv
// Command and result channel interfaces of the motor pulse brake sequencer.
`timescale 1ns / 1ps
`default_nettype none
interface mpb_cmd_if;
	import mpb_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic signed [SPEED_W-1:0] speed_d;
	logic signed [SPEED_W-1:0] speed_a;
	logic signed [SPEED_W-1:0] speed_b;
	logic [ON_W-1:0]           on_time_ms;
	logic [ON_W-1:0]           off_time_ms;

	modport source (output valid, mode, speed_d, speed_a, speed_b, on_time_ms,
		off_time_ms, input ready);
	modport sink (input valid, mode, speed_d, speed_a, speed_b, on_time_ms,
		off_time_ms, output ready);
endinterface

interface mpb_res_if #(parameter int DUTY_BITS = mpb_pkg::DUTY_BITS_DEF);
	logic                 valid;
	logic                 ready;
	logic [1:0]           dir_d;
	logic [DUTY_BITS-1:0] duty_d;
	logic [1:0]           dir_a;
	logic [DUTY_BITS-1:0] duty_a;
	logic [1:0]           dir_b;
	logic [DUTY_BITS-1:0] duty_b;
	logic [1:0]           phase;
	logic [1:0]           status;

	modport source (output valid, dir_d, duty_d, dir_a, duty_a, dir_b, duty_b, phase,
		status, input ready);
	modport sink (input valid, dir_d, duty_d, dir_a, duty_a, dir_b, duty_b, phase,
		status, output ready);
endinterface
`default_nettype wire

### design/mpb_lane.sv
// One wheel lane: drive and brake speed storage and the bridge output clamp.
`timescale 1ns / 1ps
`default_nettype none
module mpb_lane #(
	parameter int DUTY_BITS = mpb_pkg::DUTY_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               load,
	input  wire logic signed [mpb_pkg::SPEED_W-1:0] speed,
	input  wire logic [mpb_pkg::GAIN_W-1:0]         brake_gain,
	input  wire logic [mpb_pkg::CAP_W-1:0]          drive_cap,
	input  wire logic [mpb_pkg::MAXD_W-1:0]         max_duty,
	input  wire mpb_pkg::res_info_t                 info,
	output mpb_pkg::dir_t                           dir,
	output logic [DUTY_BITS-1:0]                    duty
);
	import mpb_pkg::*;

	localparam logic [CMP_W-1:0] DMAX = CMP_W'((1 << DUTY_BITS) - 1);
	localparam int RND_W = PROD_W - GAIN_FRAC;

	logic [SPEED_W-1:0] spd_u;
	logic [SPEED_W-1:0] mag_in;
	logic [SPEED_W-1:0] drive_q;
	logic [PROD_W-1:0]  prod_s1;
	logic               pos_s1;
	logic               load_s1;
	logic [CAP_W-1:0]   brk_mag_q;
	logic               brk_neg_q;
	logic [PROD_W-1:0]  rsum;
	logic [RND_W-1:0]   rnd;
	logic [CAP_W-1:0]   rmag;
	logic [SPEED_W-1:0] dmag;
	logic [SPEED_W-1:0] vmag;
	logic               vneg;
	logic [CMP_W-1:0]   lim;
	logic [CMP_W-1:0]   magc;

	assign spd_u  = speed;
	assign mag_in = spd_u[SPEED_W-1] ? (~spd_u + 1'b1) : spd_u;

	// rounded brake magnitude, clamped to the drive cap
	assign rsum = prod_s1 + ROUND_HALF;
	assign rnd  = rsum[PROD_W-1:GAIN_FRAC];
	assign rmag = (rnd > RND_W'(drive_cap)) ? drive_cap : rnd[CAP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_s1   <= 1'b0;
			drive_q   <= '0;
			prod_s1   <= '0;
			pos_s1    <= 1'b0;
			brk_mag_q <= '0;
			brk_neg_q <= 1'b0;
		end else begin
			load_s1 <= load;
			if (load) begin
				drive_q <= spd_u;
				prod_s1 <= PROD_W'(mag_in) * PROD_W'(brake_gain);
				pos_s1  <= !spd_u[SPEED_W-1] && (spd_u != '0);
			end
			if (load_s1) begin
				brk_mag_q <= rmag;
				brk_neg_q <= pos_s1;
			end
		end
	end

	assign dmag = drive_q[SPEED_W-1] ? (~drive_q + 1'b1) : drive_q;

	always_comb begin
		vmag = '0;
		vneg = 1'b0;
		if (!info.zero) begin
			case (info.phase)
				PHC_DRIVE: begin
					vmag = dmag;
					vneg = drive_q[SPEED_W-1];
				end
				PHC_BRAKE: begin
					vmag = SPEED_W'(brk_mag_q);
					vneg = brk_neg_q;
				end
				default: begin
					vmag = '0;
					vneg = 1'b0;
				end
			endcase
		end
	end

	assign lim  = (CMP_W'(max_duty) > DMAX) ? DMAX : CMP_W'(max_duty);
	assign magc = (CMP_W'(vmag) > lim) ? lim : CMP_W'(vmag);
	assign duty = magc[DUTY_BITS-1:0];

	always_comb begin
		if (magc == '0) begin
			dir = DIR_COAST;
		end else if (vneg) begin
			dir = DIR_REV;
		end else begin
			dir = DIR_FWD;
		end
	end

endmodule
`default_nettype wire

### design/mpb_seq.sv
// Phase sequencer: drive, brake and lockout counters and brake length derivation.
`timescale 1ns / 1ps
`default_nettype none
module mpb_seq #(
	parameter int TIME_BITS = mpb_pkg::TIME_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       fire,
	input  wire logic                       mode,
	input  wire logic [mpb_pkg::ON_W-1:0]   on_time_ms,
	input  wire logic [mpb_pkg::ON_W-1:0]   off_time_ms,
	input  wire logic [mpb_pkg::LIM_W-1:0]  brake_limit,
	output logic                            start_load,
	output mpb_pkg::res_info_t              info
);
	import mpb_pkg::*;

	localparam int LW = (TIME_BITS > LIM_W) ? TIME_BITS : LIM_W;
	localparam int QW = TIME_BITS - 2;
	localparam logic [LW-1:0] TMAX_L = LW'((64'd1 << TIME_BITS) - 64'd1);
	// reciprocal of the brake divisor, exact over the whole counter range
	localparam logic [TIME_BITS-1:0] DIV_M =
		TIME_BITS'(((64'd1 << (TIME_BITS + 2)) + 64'd4) / 64'(BRAKE_DIV));

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_DRIVE = 4'b0010,
		S_BRAKE = 4'b0100,
		S_LOCK  = 4'b1000
	} phase_t;

	phase_t                 phase_q, phase_n;
	logic [TIME_BITS-1:0]   cnt_q, cnt_n;
	logic [TIME_BITS-1:0]   lock_q, lock_n;
	logic [TIME_BITS-1:0]   blen_q;
	logic [TIME_BITS-1:0]   on_s1;
	logic                   v_s1;
	logic [QW-1:0]          q_s2;
	logic                   v_s2;
	logic [TIME_BITS-1:0]   on_sat;
	logic [TIME_BITS-1:0]   on_one;
	logic [TIME_BITS-1:0]   off_sat;
	logic [2*TIME_BITS-1:0] div_prod;
	logic [LW-1:0]          q_min;
	logic [LW-1:0]          lim1;
	logic [LW-1:0]          bl_l;
	logic [TIME_BITS-1:0]   bl_calc;
	logic [TIME_BITS-1:0]   bl_now;
	logic [TIME_BITS-1:0]   cnt_dec;
	logic [TIME_BITS-1:0]   lock_dec;

	assign on_sat  = (LW'(on_time_ms) > TMAX_L) ? TMAX_L[TIME_BITS-1:0]
		: TIME_BITS'(LW'(on_time_ms));
	assign on_one  = (on_sat == '0) ? TIME_BITS'(1) : on_sat;
	assign off_sat = (LW'(off_time_ms) > TMAX_L) ? TMAX_L[TIME_BITS-1:0]
		: TIME_BITS'(LW'(off_time_ms));

	assign div_prod = (2*TIME_BITS)'(on_s1) * (2*TIME_BITS)'(DIV_M);

	// brake length: quotient, at least 1, at most the limit (a zero limit counts as 1)
	assign q_min   = (q_s2 == '0) ? LW'(1) : LW'(q_s2);
	assign lim1    = (brake_limit == '0) ? LW'(1) : LW'(brake_limit);
	assign bl_l    = (q_min > lim1) ? lim1 : q_min;
	assign bl_calc = bl_l[TIME_BITS-1:0];
	// a drive that ends right after its start had an on time of 1
	assign bl_now  = v_s1 ? TIME_BITS'(1) : (v_s2 ? bl_calc : blen_q);

	assign cnt_dec  = (cnt_q == '0) ? cnt_q : cnt_q - 1'b1;
	assign lock_dec = (lock_q == '0) ? lock_q : lock_q - 1'b1;

	always_comb begin
		phase_n     = phase_q;
		cnt_n       = cnt_q;
		lock_n      = lock_q;
		start_load  = 1'b0;
		info.status = ST_OK;
		info.zero   = 1'b0;
		if (fire) begin
			if (mode) begin
				case (phase_q)
					S_LOCK: begin
						info.status = ST_REFUSED;
						info.zero   = 1'b1;
					end
					S_DRIVE, S_BRAKE: begin
						info.status = ST_BUSY;
					end
					default: begin
						start_load = 1'b1;
						cnt_n      = on_one;
						lock_n     = off_sat;
						phase_n    = S_DRIVE;
					end
				endcase
			end else begin
				case (phase_q)
					S_DRIVE: begin
						if (cnt_dec == '0) begin
							phase_n = S_BRAKE;
							cnt_n   = (bl_now == '0) ? TIME_BITS'(1) : bl_now;
						end else begin
							cnt_n = cnt_dec;
						end
					end
					S_BRAKE: begin
						cnt_n = cnt_dec;
						if (cnt_dec == '0) begin
							phase_n = (lock_q != '0) ? S_LOCK : S_IDLE;
						end
					end
					S_LOCK: begin
						lock_n = lock_dec;
						if (lock_dec == '0) begin
							phase_n = S_IDLE;
						end
					end
					default: begin
						phase_n = S_IDLE;
					end
				endcase
			end
		end
		case (phase_n)
			S_DRIVE: info.phase = PHC_DRIVE;
			S_BRAKE: info.phase = PHC_BRAKE;
			S_LOCK:  info.phase = PHC_LOCK;
			default: info.phase = PHC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= S_IDLE;
			cnt_q   <= '0;
			lock_q  <= '0;
			blen_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			on_s1   <= '0;
			q_s2    <= '0;
		end else begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			lock_q  <= lock_n;
			v_s1    <= start_load;
			v_s2    <= v_s1;
			if (start_load) begin
				on_s1 <= on_one;
			end
			if (v_s1) begin
				q_s2 <= div_prod[2*TIME_BITS-1:TIME_BITS+2];
			end
			if (v_s2) begin
				blen_q <= bl_calc;
			end
		end
	end

endmodule
`default_nettype wire

### design/motor_pulse_brake_sequencer_top.sv
// Top level of the motor pulse brake sequencer: registers, lanes and result stage.
//
// Usage: each word on cmd is either a one millisecond tick (mode 0) or a start
// command (mode 1) carrying three wheel speeds, an on time and an off time.
// Every cmd word yields exactly one word on res: the bridge direction and duty
// of wheels D, A and B, the phase after the word, and a status code.
// Registers are written over the cfg port (cfg_we, cfg_index, cfg_data); the user
// must write them only while no word is in flight; the block does not enforce it.
// Result path: an accepted word is registered into the internal stage (iv_s1,
// info_s1) and then into the result stage (rv_s2 and the result registers).
// Throughput: one word per cycle while the result stage can advance; the
// phase counters update in the accept cycle, the three wheel lanes load their
// drive speeds there, and the brake scale multiply and the divide by five run
// in two-stage side pipes that complete before any later word can need them.
// Reset: phase idle, counters cleared, registers at their default values,
// no result pending.
// Stall: while res.ready is low the result word holds; one further word is
// taken into the internal stage, after which cmd.ready drops.
`timescale 1ns / 1ps
`default_nettype none
module motor_pulse_brake_sequencer_top #(
	parameter int DUTY_BITS = mpb_pkg::DUTY_BITS_DEF,
	parameter int TIME_BITS = mpb_pkg::TIME_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	mpb_cmd_if.sink                             cmd,
	mpb_res_if.source                           res,
	input  wire logic                           cfg_we,
	input  wire logic [mpb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mpb_pkg::CFG_W-1:0]      cfg_data
);
	import mpb_pkg::*;

	logic [MAXD_W-1:0]    max_duty_q;
	logic [CAP_W-1:0]     drive_cap_q;
	logic [GAIN_W-1:0]    brake_gain_q;
	logic [LIM_W-1:0]     brake_lim_q;

	logic                 fire;
	logic                 adv;
	logic                 start_load;
	res_info_t            info;
	res_info_t            info_s1;
	logic                 iv_s1;
	logic                 rv_s2;

	dir_t                 dir_d, dir_a, dir_b;
	logic [DUTY_BITS-1:0] duty_d, duty_a, duty_b;
	logic [1:0]           dir_d_s2, dir_a_s2, dir_b_s2;
	logic [DUTY_BITS-1:0] duty_d_s2, duty_a_s2, duty_b_s2;
	logic [1:0]           phase_s2;
	logic [1:0]           status_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_duty_q   <= MAX_DUTY_RST;
			drive_cap_q  <= DRIVE_CAP_RST;
			brake_gain_q <= BRAKE_GAIN_RST;
			brake_lim_q  <= BRAKE_LIM_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MAX_DUTY:   max_duty_q   <= cfg_data[MAXD_W-1:0];
				CFG_DRIVE_CAP:  drive_cap_q  <= cfg_data[CAP_W-1:0];
				CFG_BRAKE_GAIN: brake_gain_q <= cfg_data[GAIN_W-1:0];
				CFG_BRAKE_LIM:  brake_lim_q  <= cfg_data[LIM_W-1:0];
				default:        max_duty_q   <= max_duty_q;
			endcase
		end
	end

	assign adv       = !rv_s2 || res.ready;
	assign cmd.ready = !iv_s1 || adv;
	assign fire      = cmd.valid && cmd.ready;

	mpb_seq #(.TIME_BITS(TIME_BITS)) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.mode        (cmd.mode),
		.on_time_ms  (cmd.on_time_ms),
		.off_time_ms (cmd.off_time_ms),
		.brake_limit (brake_lim_q),
		.start_load  (start_load),
		.info        (info)
	);

	mpb_lane #(.DUTY_BITS(DUTY_BITS)) u_lane_d (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (start_load),
		.speed      (cmd.speed_d),
		.brake_gain (brake_gain_q),
		.drive_cap  (drive_cap_q),
		.max_duty   (max_duty_q),
		.info       (info_s1),
		.dir        (dir_d),
		.duty       (duty_d)
	);

	mpb_lane #(.DUTY_BITS(DUTY_BITS)) u_lane_a (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (start_load),
		.speed      (cmd.speed_a),
		.brake_gain (brake_gain_q),
		.drive_cap  (drive_cap_q),
		.max_duty   (max_duty_q),
		.info       (info_s1),
		.dir        (dir_a),
		.duty       (duty_a)
	);

	mpb_lane #(.DUTY_BITS(DUTY_BITS)) u_lane_b (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (start_load),
		.speed      (cmd.speed_b),
		.brake_gain (brake_gain_q),
		.drive_cap  (drive_cap_q),
		.max_duty   (max_duty_q),
		.info       (info_s1),
		.dir        (dir_b),
		.duty       (duty_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_s1 <= 1'b0;
			rv_s2 <= 1'b0;
		end else begin
			if (fire) begin
				iv_s1 <= 1'b1;
			end else if (adv) begin
				iv_s1 <= 1'b0;
			end
			if (adv) begin
				rv_s2 <= iv_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			info_s1 <= info;
		end
		if (adv && iv_s1) begin
			dir_d_s2  <= dir_d;
			duty_d_s2 <= duty_d;
			dir_a_s2  <= dir_a;
			duty_a_s2 <= duty_a;
			dir_b_s2  <= dir_b;
			duty_b_s2 <= duty_b;
			phase_s2  <= info_s1.phase;
			status_s2 <= info_s1.status;
		end
	end

	assign res.valid  = rv_s2;
	assign res.dir_d  = dir_d_s2;
	assign res.duty_d = duty_d_s2;
	assign res.dir_a  = dir_a_s2;
	assign res.duty_a = duty_a_s2;
	assign res.dir_b  = dir_b_s2;
	assign res.duty_b = duty_b_s2;
	assign res.phase  = phase_s2;
	assign res.status = status_s2;

endmodule
`default_nettype wire

### design/mpb_checker.sv
// Port-level assertions of the motor pulse brake sequencer and their binding.
`timescale 1ns / 1ps
`default_nettype none
module mpb_checker #(
	parameter int DUTY_BITS = mpb_pkg::DUTY_BITS_DEF
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 res_valid,
	input wire logic                 res_ready,
	input wire logic [1:0]           dir_d,
	input wire logic [DUTY_BITS-1:0] duty_d,
	input wire logic [1:0]           dir_a,
	input wire logic [DUTY_BITS-1:0] duty_a,
	input wire logic [1:0]           dir_b,
	input wire logic [DUTY_BITS-1:0] duty_b,
	input wire logic [1:0]           phase,
	input wire logic [1:0]           status
);
	import mpb_pkg::*;

	logic all_coast;
	assign all_coast = (dir_d == DIR_COAST) && (dir_a == DIR_COAST) && (dir_b == DIR_COAST)
		&& (duty_d == '0) && (duty_a == '0) && (duty_b == '0);

	// stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable({dir_d, duty_d, dir_a, duty_a,
			dir_b, duty_b, phase, status}))
		else $error("result word changed while stalled");

	// a refused start leaves the block in lockout with all wheels stopped
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_REFUSED) |-> (phase == PHC_LOCK) && all_coast)
		else $error("refused start not in lockout or wheels driven");

	// an ignored start only happens while a pulse runs
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_BUSY) |-> (phase == PHC_DRIVE) || (phase == PHC_BRAKE))
		else $error("busy status outside drive or brake");

	// wheels never driven in idle or lockout, and idle always reports ok
	a_idle_stop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ((phase == PHC_IDLE) || (phase == PHC_LOCK)) |->
			all_coast && ((phase == PHC_LOCK) || (status == ST_OK)))
		else $error("wheels driven in idle or lockout");

endmodule

bind motor_pulse_brake_sequencer_top mpb_checker #(.DUTY_BITS(DUTY_BITS)) u_mpb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.dir_d     (res.dir_d),
	.duty_d    (res.duty_d),
	.dir_a     (res.dir_a),
	.duty_a    (res.duty_a),
	.dir_b     (res.dir_b),
	.duty_b    (res.duty_b),
	.phase     (res.phase),
	.status    (res.status)
);
`default_nettype wire
